// ===== rtl/assert_macros.svh =====
// assertion helpers included by led_chain_pulse_serializer_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lcps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcps_pkg
// Types and constants of the led chain pulse serializer.
// ----------------------------------------------------------------------------
package lcps_pkg;

  localparam int MAX_LEDS_DEF     = 256;
  localparam int BITS_PER_LED_DEF = 24;

  localparam int COLOR_W = 24;
  localparam int INDEX_W = 8;
  localparam int OP_W    = 2;
  localparam int TICK_W  = 16;
  localparam int PULSE_W = 10;
  localparam int COUNT_W = 9;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  // register indexes
  localparam logic [1:0] REG_SHORT_TICKS = 2'd0;
  localparam logic [1:0] REG_LONG_TICKS  = 2'd1;
  localparam logic [1:0] REG_RESET_TICKS = 2'd2;
  localparam logic [1:0] REG_LED_COUNT   = 2'd3;

  localparam logic [PULSE_W-1:0] SHORT_TICKS_RST = 10'd25;
  localparam logic [PULSE_W-1:0] LONG_TICKS_RST  = 10'd100;
  localparam logic [TICK_W-1:0]  RESET_TICKS_RST = 16'd3000;
  localparam logic [COUNT_W-1:0] LED_COUNT_RST   = 9'd1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

endpackage

// ===== rtl/led_chain_pulse_serializer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_chain_pulse_serializer_top
// One-wire pulse-width serializer for a chain of addressable rgb leds.
// ----------------------------------------------------------------------------
// Each input item on the s_ channel is one tick of the waveform timer. It may
// also write a color into the pixel store (operation 1) or start a frame
// (operation 2). Every item yields exactly one result item on the m_ channel
// carrying the line level, the busy flag and the frame_done pulse of that tick.
// A frame sends led_count pixels (at most MAX_LEDS) msb first; a one bit is high
// for long_ticks then low for short_ticks, a zero bit the other way round, and a
// low latch period of reset_ticks closes the frame.
// An item enters the input register when accepted; its result is loaded into
// the result register, raising m_tvalid, when the item advances, which waits
// while the receiver stalls. The block takes one item per cycle while the
// receiver keeps up, set by the single pass of next-state logic; the store is
// read ahead of need, so the registered memory read never stalls the stream.
// Reset clears the timer state, the registers go to their defaults, the store
// keeps whatever it held. When the receiver stalls, the result register
// holds, the input register fills, and s_tready drops until m_tready returns.
// Registers are written over the apb port, by the user only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_chain_pulse_serializer_top #(
  parameter int MAX_LEDS     = lcps_pkg::MAX_LEDS_DEF,
  parameter int BITS_PER_LED = lcps_pkg::BITS_PER_LED_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata: operation[1:0], pixel_index[9:2], pixel_color[33:10], zero pad
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lcps_pkg::IN_DATA_W-1:0]   s_tdata,
  // m_tdata: line_level[0], busy_res[1], frame_done[2], zero pad
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lcps_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lcps_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lcps_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lcps_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int PCW = $clog2(MAX_LEDS + 1);
  localparam int LW  = (PCW > lcps_pkg::COUNT_W) ? PCW : lcps_pkg::COUNT_W;
  localparam int BCW = $clog2(BITS_PER_LED);
  localparam int TW  = lcps_pkg::TICK_W;

  // configuration registers
  logic [lcps_pkg::PULSE_W-1:0] short_ticks;
  logic [lcps_pkg::PULSE_W-1:0] long_ticks;
  logic [TW-1:0]                reset_ticks;
  logic [lcps_pkg::COUNT_W-1:0] led_count;
  logic                         cfg_wr;

  // input register
  logic                         in_valid_q;
  logic [lcps_pkg::OP_W-1:0]    op_q;
  logic [lcps_pkg::INDEX_W-1:0] idx_q;
  logic [lcps_pkg::COLOR_W-1:0] color_q;
  logic                         advance;

  // serializer state
  lcps_pkg::phase_t   phase, phase_next, ph_s;
  logic [TW-1:0]      tick_counter, tick_counter_next, tc_s, tc_inc;
  logic [PCW-1:0]     pixel_counter, pixel_counter_next, pc_s;
  logic [BCW-1:0]     bit_counter, bit_counter_next, bc_s;
  logic [BITS_PER_LED-1:0] shift_word, shift_word_next, sw_s;
  logic               latch_end;

  // pixel store and look-ahead read
  logic [lcps_pkg::COLOR_W-1:0] pixel_store [MAX_LEDS];
  logic [AW-1:0]                rd_addr_next, rd_addr_q;
  logic [lcps_pkg::COLOR_W-1:0] rd_data;
  logic                         wr_now, wr_q;
  logic [AW-1:0]                wr_addr, wr_addr_q;
  logic [lcps_pkg::COLOR_W-1:0] wr_data_q;
  logic [lcps_pkg::COLOR_W-1:0] load_word;

  logic [TW-1:0] sh, lg, rt;
  logic [LW-1:0] led_ext, max_ext, frame_leds, pc_inc;
  logic          cur_bit, line_c, busy_c;

  // ---------------------------------------------------------------- apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= lcps_pkg::SHORT_TICKS_RST;
      long_ticks  <= lcps_pkg::LONG_TICKS_RST;
      reset_ticks <= lcps_pkg::RESET_TICKS_RST;
      led_count   <= lcps_pkg::LED_COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lcps_pkg::REG_SHORT_TICKS: short_ticks <= pwdata[lcps_pkg::PULSE_W-1:0];
        lcps_pkg::REG_LONG_TICKS:  long_ticks  <= pwdata[lcps_pkg::PULSE_W-1:0];
        lcps_pkg::REG_RESET_TICKS: reset_ticks <= pwdata[TW-1:0];
        lcps_pkg::REG_LED_COUNT:   led_count   <= pwdata[lcps_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lcps_pkg::REG_SHORT_TICKS: prdata = 32'(short_ticks);
      lcps_pkg::REG_LONG_TICKS:  prdata = 32'(long_ticks);
      lcps_pkg::REG_RESET_TICKS: prdata = 32'(reset_ticks);
      lcps_pkg::REG_LED_COUNT:   prdata = 32'(led_count);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign advance  = in_valid_q && (!m_tvalid || m_tready);
  assign s_tready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q    <= s_tdata[1:0];
      idx_q   <= s_tdata[9:2];
      color_q <= s_tdata[33:10];
    end
  end

  // ---------------------------------------------------------------- timing
  assign sh = (short_ticks == '0) ? TW'(1) : TW'(short_ticks);
  assign lg = (long_ticks == '0) ? TW'(1) : TW'(long_ticks);
  assign rt = (reset_ticks == '0) ? TW'(1) : reset_ticks;

  assign led_ext    = LW'(led_count);
  assign max_ext    = LW'(MAX_LEDS);
  assign frame_leds = (led_ext > max_ext) ? max_ext : led_ext;

  // ---------------------------------------------------------------- store
  assign wr_now  = advance && (op_q == lcps_pkg::OP_WRITE) && (32'(idx_q) < 32'(MAX_LEDS));
  assign wr_addr = AW'(idx_q);

  always_ff @(posedge clk) begin
    if (wr_now) begin
      pixel_store[wr_addr] <= color_q;
    end
    rd_data   <= pixel_store[rd_addr_next];
    rd_addr_q <= rd_addr_next;
    wr_addr_q <= wr_addr;
    wr_data_q <= color_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q <= 1'b0;
    end else begin
      wr_q <= wr_now;
    end
  end

  // newest write to the prefetched entry wins: this tick, then last tick
  always_comb begin
    if (wr_now && (wr_addr == rd_addr_q)) begin
      load_word = color_q;
    end else if (wr_q && (wr_addr_q == rd_addr_q)) begin
      load_word = wr_data_q;
    end else begin
      load_word = rd_data;
    end
  end

  // always fetch the pixel that the next load will need
  assign rd_addr_next = (phase_next == lcps_pkg::PH_IDLE) ? '0
                      : AW'(pixel_counter_next + PCW'(1));

  // ---------------------------------------------------------------- frame start
  always_comb begin
    ph_s = phase;
    tc_s = tick_counter;
    pc_s = pixel_counter;
    bc_s = bit_counter;
    sw_s = shift_word;
    if (op_q == lcps_pkg::OP_START && phase == lcps_pkg::PH_IDLE) begin
      pc_s = '0;
      tc_s = '0;
      if (frame_leds == '0) begin
        ph_s = lcps_pkg::PH_LATCH;
      end else begin
        sw_s = BITS_PER_LED'(load_word);
        bc_s = '0;
        ph_s = lcps_pkg::PH_HIGH;
      end
    end
  end

  assign cur_bit = sw_s[BITS_PER_LED-1];
  assign tc_inc  = tc_s + TW'(1);
  assign pc_inc  = LW'(pc_s) + LW'(1);

  // ---------------------------------------------------------------- next state
  always_comb begin
    phase_next         = phase;
    tick_counter_next  = tick_counter;
    pixel_counter_next = pixel_counter;
    bit_counter_next   = bit_counter;
    shift_word_next    = shift_word;
    latch_end          = 1'b0;
    if (advance) begin
      phase_next         = ph_s;
      tick_counter_next  = tc_s;
      pixel_counter_next = pc_s;
      bit_counter_next   = bc_s;
      shift_word_next    = sw_s;
      case (ph_s)
        lcps_pkg::PH_HIGH: begin
          tick_counter_next = tc_inc;
          if (tc_inc >= (cur_bit ? lg : sh)) begin
            phase_next        = lcps_pkg::PH_LOW;
            tick_counter_next = '0;
          end
        end
        lcps_pkg::PH_LOW: begin
          tick_counter_next = tc_inc;
          if (tc_inc >= (cur_bit ? sh : lg)) begin
            tick_counter_next = '0;
            if (bc_s >= BCW'(BITS_PER_LED - 1)) begin
              pixel_counter_next = PCW'(pc_inc);
              if (pc_inc >= frame_leds) begin
                phase_next       = lcps_pkg::PH_LATCH;
                shift_word_next  = '0;
                bit_counter_next = '0;
              end else begin
                shift_word_next  = BITS_PER_LED'(load_word);
                bit_counter_next = '0;
                phase_next       = lcps_pkg::PH_HIGH;
              end
            end else begin
              bit_counter_next = bc_s + BCW'(1);
              shift_word_next  = {sw_s[BITS_PER_LED-2:0], 1'b0};
              phase_next       = lcps_pkg::PH_HIGH;
            end
          end
        end
        lcps_pkg::PH_LATCH: begin
          tick_counter_next = tc_inc;
          if (tc_inc >= rt) begin
            latch_end          = 1'b1;
            phase_next         = lcps_pkg::PH_IDLE;
            tick_counter_next  = '0;
            pixel_counter_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    line_c = 1'b0;
    busy_c = 1'b0;
    case (ph_s)
      lcps_pkg::PH_HIGH: begin
        line_c = 1'b1;
        busy_c = 1'b1;
      end
      lcps_pkg::PH_LOW:   busy_c = 1'b1;
      lcps_pkg::PH_LATCH: busy_c = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lcps_pkg::PH_IDLE;
      tick_counter  <= '0;
      pixel_counter <= '0;
      bit_counter   <= '0;
      shift_word    <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      phase         <= phase_next;
      tick_counter  <= tick_counter_next;
      pixel_counter <= pixel_counter_next;
      bit_counter   <= bit_counter_next;
      shift_word    <= shift_word_next;
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'b0, latch_end, busy_c, line_c};
    end
  end

  // ---------------------------------------------------------------- checks
  `ASSERT_SAME(a_done_is_busy, m_tvalid && m_tdata[2], m_tdata[1],
               "frame_done without busy")
  `ASSERT_NEXT(a_done_goes_idle, advance && latch_end, phase == lcps_pkg::PH_IDLE,
               "latch end did not return to idle")
  `ASSERT_SAME(a_latch_word_clear, phase == lcps_pkg::PH_LATCH, shift_word == '0,
               "shift word not cleared in latch period")
  `ASSERT_SAME(a_bit_range, phase == lcps_pkg::PH_HIGH || phase == lcps_pkg::PH_LOW,
               bit_counter <= BCW'(BITS_PER_LED - 1), "bit counter past last bit")
  `ASSERT_NEXT(a_result_loaded, advance, m_tvalid, "processed item left no result")

endmodule
